@@ sv/cpaf_pkg.sv @@
package cpaf_pkg;

    localparam int MaxVertices  = 64;
    localparam int MaxEdges     = 64;
    localparam int DurationBits = 16;
    localparam int VW = 6;   // vertex index width
    localparam int EW = 6;   // edge index width
    localparam int CW = 7;   // count width (holds 64)
    localparam int TW = 24;  // signed event time width

    localparam logic [1:0] StCrit  = 2'd0;
    localparam logic [1:0] StCycle = 2'd1;
    localparam logic [1:0] StNone  = 2'd2;

    localparam logic [0:0] RegVertexCount = 1'd0;

    typedef logic signed [TW-1:0] time_t;

    typedef struct packed {
        logic [VW-1:0]           src;
        logic [VW-1:0]           dst;
        logic [DurationBits-1:0] dur;
    } edge_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [VW-1:0]           crit_src;
        logic [VW-1:0]           crit_dst;
        logic [DurationBits-1:0] crit_length;
        logic                    last_result;
    } result_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_DEG_RD, S_DEG_WAIT, S_DEG_WR,
        S_SEED_RD, S_SEED_WAIT, S_SEED_CHK,
        S_POP, S_POP_WAIT, S_POP_T,
        S_FW_RD, S_FW_WAIT, S_FW_WR,
        S_CHK,
        S_LT_INIT,
        S_BW_V, S_BW_VWAIT, S_BW_VT, S_BW_RD, S_BW_WAIT, S_BW_WR,
        S_EM_V, S_EM_VWAIT, S_EM_RD, S_EM_WAIT, S_EM_OUT,
        S_FIN
    } state_t;

endpackage

@@ sv/cpaf_if.sv @@
interface cpaf_edge_if;
    import cpaf_pkg::*;
    logic  valid;
    logic  ready;
    edge_t data;
    logic  last_edge;
    modport source (output valid, data, last_edge, input ready);
    modport sink   (input valid, data, last_edge, output ready);
endinterface

interface cpaf_result_if;
    import cpaf_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ sv/critical_path_activity_finder_core.sv @@
// Critical path finder for an activity-on-edge network. Edges load one word
// per cycle while no result word waits on the output, into a 64-entry edge
// memory until the word with last_edge set. The network is then solved by
// passes over the edge memory, each edge visit being a memory read, a wait
// and a read-modify-write: an in-degree pass, a seed pass over vertices, a
// topological/forward pass, a latest-time init, a backward pass and an emit
// pass that can stall on the output. No input is taken while solving.
// Critical edges come out ordered by source vertex then load order, with
// last_result on the final word; each critical word is held back until the
// next is found or the pass ends. A cycle gives one status-1 word, no
// critical edge one status-2 word.
module critical_path_activity_finder_core
    import cpaf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    cpaf_edge_if.sink     edge_in,
    cpaf_result_if.source result_out
);
    logic [CW-1:0] n_eff;

    cpaf_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .n_eff(n_eff));

    cpaf_engine u_engine (
        .clk(clk), .rst_n(rst_n), .n_eff(n_eff), .in_ch(edge_in), .out_ch(result_out));

    // a critical word never carries a vertex beyond the configured count
    a_src_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.data.status == StCrit
        |-> {1'b0, result_out.data.crit_src} < n_eff)
        else $error("critical edge source out of range");

    // error words carry the last flag
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.data.status != StCrit
        |-> result_out.data.last_result)
        else $error("error word without last flag");
endmodule

@@ sv/cpaf_ram.sv @@
module cpaf_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/cpaf_cfg.sv @@
module cpaf_cfg
    import cpaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [CW-1:0] n_eff
);
    logic [CW-1:0] vcount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CW'(1);
        end
        else if (psel && penable && pwrite && paddr[2] == RegVertexCount)
        begin
            vcount_reg <= pwdata[CW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegVertexCount) ? {25'd0, vcount_reg} : 32'd0;

    // clamp to 1..MaxVertices
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (vcount_reg > CW'(MaxVertices))
        begin
            n_eff = CW'(MaxVertices);
        end
        else
        begin
            n_eff = vcount_reg;
        end
    end
endmodule

@@ sv/cpaf_engine.sv @@
module cpaf_engine
    import cpaf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [CW-1:0] n_eff,
    cpaf_edge_if.sink     in_ch,
    cpaf_result_if.source out_ch
);
    state_t state_reg, state_next;

    logic [CW-1:0] ecount_reg, ecount_next;
    logic [CW-1:0] j_reg, j_next;       // edge / vertex walker
    logic [CW-1:0] top_reg, top_next;
    logic [CW-1:0] done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] v_reg, v_next;
    time_t         tv_reg, tv_next;     // time of current vertex
    time_t         sink_t_reg, sink_t_next;
    logic          ovalid_reg, ovalid_next;
    result_t       odata_reg, odata_next;
    logic          pend_reg, pend_next;   // critical word held back one place
    result_t       pdata_reg, pdata_next;

    // memories
    logic          e_we;  logic [EW-1:0] e_wa, e_ra;  edge_t e_wd, e_rd;
    logic          d_we;  logic [VW-1:0] d_wa, d_ra;  logic [CW-1:0] d_wd, d_rd;
    logic          t_we;  logic [VW-1:0] t_wa, t_ra;  time_t t_wd, t_rd;
    logic          o_we;  logic [VW-1:0] o_wa, o_ra;  logic [VW-1:0] o_wd, o_rd;
    logic          k_we;  logic [VW-1:0] k_wa, k_ra;  logic [VW-1:0] k_wd, k_rd;
    logic [MaxVertices-1:0] dval_reg, dval_next; // in-degree valid bits

    cpaf_ram #(.Width($bits(edge_t)), .Depth(MaxEdges)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
    cpaf_ram #(.Width(CW), .Depth(MaxVertices)) u_deg (
        .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
    cpaf_ram #(.Width(TW), .Depth(MaxVertices)) u_time (
        .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
    cpaf_ram #(.Width(VW), .Depth(MaxVertices)) u_topo (
        .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
    cpaf_ram #(.Width(VW), .Depth(MaxVertices)) u_stack (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

    // latest times go to u_late, not u_time: the backward pass writes latest,
    // and earliest of each vertex is still needed in emit, so keep a second store
    logic  l_we; logic [VW-1:0] l_wa, l_ra; time_t l_wd, l_rd;
    cpaf_ram #(.Width(TW), .Depth(MaxVertices)) u_late (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));

    logic [CW-1:0] deg_rd;
    logic [VW-1:0] d_ra_q;
    assign deg_rd = dval_reg[d_ra_q] ? d_rd : '0;
    always_ff @(posedge clk) d_ra_q <= d_ra;

    logic e_ok;
    assign e_ok = ({1'b0, e_rd.src} < n_eff) && ({1'b0, e_rd.dst} < n_eff);
    time_t dur_t;
    assign dur_t = time_t'({1'b0, e_rd.dur});

    assign in_ch.ready = (state_reg == S_LOAD) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            ecount_reg <= '0;
            dval_reg   <= '0;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            j_reg <= '0; top_reg <= '0; done_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ecount_reg <= ecount_next;
            dval_reg   <= dval_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
            j_reg <= j_next; top_reg <= top_next; done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next; tv_reg <= tv_next; sink_t_reg <= sink_t_next;
        odata_reg <= odata_next;
        pdata_reg <= pdata_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:      if (in_ch.valid && in_ch.ready && in_ch.last_edge)
                             state_next = (ecount_reg == CW'(MaxEdges) && 1'b0) ? S_LOAD
                                                                             : S_DEG_RD;
            S_DEG_RD:    state_next = (j_reg == ecount_reg) ? S_SEED_RD : S_DEG_WAIT;
            S_DEG_WAIT:  state_next = S_DEG_WR;
            S_DEG_WR:    state_next = S_DEG_RD;
            S_SEED_RD:   state_next = (j_reg == n_eff) ? S_POP : S_SEED_WAIT;
            S_SEED_WAIT: state_next = S_SEED_CHK;
            S_SEED_CHK:  state_next = S_SEED_RD;
            S_POP:       state_next = (top_reg == '0) ? S_CHK : S_POP_WAIT;
            S_POP_WAIT:  state_next = S_POP_T;
            S_POP_T:     state_next = S_FW_RD;
            S_FW_RD:     state_next = (j_reg == ecount_reg) ? S_POP : S_FW_WAIT;
            S_FW_WAIT:   state_next = S_FW_WR;
            S_FW_WR:     state_next = S_FW_RD;
            S_CHK:       state_next = (done_reg < n_eff) ? S_FIN : S_LT_INIT;
            S_LT_INIT:   state_next = (j_reg == n_eff) ? S_BW_V : S_LT_INIT;
            S_BW_V:      state_next = (done_reg == '0) ? S_EM_V : S_BW_VWAIT;
            S_BW_VWAIT:  state_next = S_BW_VT;
            S_BW_VT:     state_next = S_BW_RD;
            S_BW_RD:     state_next = (j_reg == ecount_reg) ? S_BW_V : S_BW_WAIT;
            S_BW_WAIT:   state_next = S_BW_WR;
            S_BW_WR:     state_next = S_BW_RD;
            S_EM_V:      state_next = (done_reg == n_eff) ? S_FIN : S_EM_VWAIT;
            S_EM_VWAIT:  state_next = S_EM_RD;
            S_EM_RD:     state_next = (j_reg == ecount_reg) ? S_EM_V : S_EM_WAIT;
            S_EM_WAIT:   state_next = S_EM_OUT;
            S_EM_OUT:    if (!ovalid_reg || out_ch.ready) state_next = S_EM_RD;
            S_FIN:       if (!ovalid_reg || out_ch.ready) state_next = S_LOAD;
            default:     state_next = S_LOAD;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        ecount_next = ecount_reg; j_next = j_reg; top_next = top_reg;
        done_next = done_reg; cnt_next = cnt_reg; v_next = v_reg; tv_next = tv_reg;
        sink_t_next = sink_t_reg; dval_next = dval_reg;
        ovalid_next = ovalid_reg && !out_ch.ready; odata_next = odata_reg;
        pend_next = pend_reg; pdata_next = pdata_reg;
        e_we = 1'b0; e_wa = ecount_reg[EW-1:0];
        e_wd = in_ch.data; e_ra = j_reg[EW-1:0];
        d_we = 1'b0; d_wa = e_rd.dst; d_wd = '0; d_ra = e_rd.dst;
        t_we = 1'b0; t_wa = e_rd.dst; t_wd = '0; t_ra = e_rd.dst;
        l_we = 1'b0; l_wa = e_rd.dst; l_wd = '0; l_ra = e_rd.dst;
        o_we = 1'b0; o_wa = done_reg[VW-1:0]; o_wd = v_reg; o_ra = done_reg[VW-1:0];
        k_we = 1'b0; k_wa = top_reg[VW-1:0]; k_wd = '0; k_ra = top_reg[VW-1:0] - 1'b1;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    if (ecount_reg != CW'(MaxEdges))
                    begin
                        e_we = 1'b1;
                        ecount_next = ecount_reg + 1'b1;
                    end
                    j_next = '0; top_next = '0; done_next = '0; cnt_next = '0;
                    dval_next = '0;
                end
            end
            S_DEG_RD:
            begin
                if (j_reg == ecount_reg) j_next = '0;
            end
            S_DEG_WAIT: ;
            S_DEG_WR:
            begin
                if (e_ok)
                begin
                    d_we = 1'b1; d_wd = deg_rd + 1'b1;
                    dval_next[e_rd.dst] = 1'b1;
                end
                j_next = j_reg + 1'b1;
            end
            S_SEED_RD:
            begin
                d_ra = j_reg[VW-1:0];
                t_we = (j_reg != n_eff); t_wa = j_reg[VW-1:0]; t_wd = '0;
            end
            S_SEED_WAIT:
            begin
                d_ra = j_reg[VW-1:0];
            end
            S_SEED_CHK:
            begin
                if (deg_rd == '0)
                begin
                    k_we = 1'b1; k_wd = j_reg[VW-1:0]; top_next = top_reg + 1'b1;
                end
                j_next = j_reg + 1'b1;
            end
            S_POP:
            begin
                top_next = (top_reg == '0) ? top_reg : top_reg - 1'b1;
            end
            S_POP_WAIT:
            begin
                t_ra = k_rd;
                v_next = k_rd;
            end
            S_POP_T:
            begin
                tv_next = t_rd;
                o_we = 1'b1;
                done_next = done_reg + 1'b1;
                j_next = '0;
            end
            S_FW_RD: ;
            S_FW_WAIT: ;
            S_FW_WR:
            begin
                if (e_rd.src == v_reg && {1'b0, e_rd.dst} < n_eff)
                begin
                    d_we = 1'b1; d_wd = deg_rd - 1'b1;
                    if (deg_rd == CW'(1))
                    begin
                        k_we = 1'b1; k_wd = e_rd.dst; top_next = top_reg + 1'b1;
                    end
                    if (tv_reg + dur_t > t_rd)
                    begin
                        t_we = 1'b1; t_wd = tv_reg + dur_t;
                    end
                end
                j_next = j_reg + 1'b1;
            end
            S_CHK:
            begin
                j_next = '0;
                t_ra = VW'(n_eff - 1'b1);
                if (done_reg < n_eff)
                begin
                    ovalid_next = 1'b1;
                    odata_next = '{status: StCycle, crit_src: '0, crit_dst: '0,
                                   crit_length: '0, last_result: 1'b1};
                end
            end
            S_LT_INIT:
            begin
                if (j_reg == '0) sink_t_next = t_rd;
                l_we = (j_reg != n_eff); l_wa = j_reg[VW-1:0];
                l_wd = (j_reg == '0) ? t_rd : sink_t_reg;
                j_next = j_reg + 1'b1;
            end
            S_BW_V:
            begin
                o_ra = VW'(done_reg - 1'b1);
                if (done_reg != '0) done_next = done_reg - 1'b1;
                j_next = '0;
            end
            S_BW_VWAIT:
            begin
                v_next = o_rd; l_ra = o_rd;
            end
            S_BW_VT:
            begin
                tv_next = l_rd;
            end
            S_BW_RD: ;
            S_BW_WAIT: ;
            S_BW_WR:
            begin
                if (e_rd.src == v_reg && {1'b0, e_rd.dst} < n_eff &&
                    l_rd - dur_t < tv_reg)
                begin
                    tv_next = l_rd - dur_t;
                    l_we = 1'b1; l_wa = v_reg; l_wd = l_rd - dur_t;
                end
                j_next = j_reg + 1'b1;
            end
            S_EM_V:
            begin
                t_ra = done_reg[VW-1:0];
                v_next = done_reg[VW-1:0];
                j_next = '0;
            end
            S_EM_VWAIT:
            begin
                tv_next = t_rd;
                done_next = done_reg + 1'b1;
            end
            S_EM_RD: ;
            S_EM_WAIT: ;
            S_EM_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    // a new find releases the held word; the newest stays held
                    if (e_rd.src == v_reg && {1'b0, e_rd.dst} < n_eff &&
                        tv_reg == l_rd - dur_t)
                    begin
                        if (pend_reg)
                        begin
                            ovalid_next = 1'b1;
                            odata_next = pdata_reg;
                        end
                        pend_next = 1'b1; cnt_next = cnt_reg + 1'b1;
                        pdata_next = '{status: StCrit, crit_src: e_rd.src,
                                       crit_dst: e_rd.dst, crit_length: e_rd.dur,
                                       last_result: 1'b0};
                    end
                    j_next = j_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                // held word goes out flagged last, or a no-critical word
                if (!ovalid_reg || out_ch.ready)
                begin
                    ecount_next = '0;
                    if (pend_reg)
                    begin
                        ovalid_next = 1'b1;
                        odata_next = pdata_reg;
                        odata_next.last_result = 1'b1;
                        pend_next = 1'b0;
                    end
                    else if (done_reg == n_eff && cnt_reg == '0)
                    begin
                        ovalid_next = 1'b1;
                        odata_next = '{status: StNone, crit_src: '0, crit_dst: '0,
                                       crit_length: '0, last_result: 1'b1};
                    end
                end
            end
            default: ;
        endcase
    end
endmodule
